### rtl/sbpa_pkg.sv
package sbpa_pkg;

    localparam int MAX_SLICES_D = 64;
    localparam int MAX_ATOMS_D  = 65536;
    localparam int FRAC_BITS_D  = 16;

    localparam int SUM_W  = 48;
    localparam int HITS_W = 17;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ZLOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZHIGH = 3'd2;
    localparam logic [IDX_W-1:0] REG_COUNT = 3'd3;
    localparam logic [IDX_W-1:0] REG_INV   = 3'd4;
    localparam logic [IDX_W-1:0] REG_BOXY  = 3'd5;

    localparam logic signed [SUM_W-1:0] S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

    typedef struct packed {
        logic [15:0]        atom_index;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] image_y;
        logic signed [31:0] vel_y;
        logic               frame_end;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        frame_number;
        logic [5:0]         slice_index;
        logic signed [47:0] slice_average;
        logic               last_slice;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word
        logic mul;       // read slice k, register its index
        logic upd;       // read-modify-write slice, store position
        logic rd;        // read slice c for report
        logic div_start; // start divide
        logic cap;       // capture result word
        logic clr;       // clear slice c
        logic first_clr; // leave first frame
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_end;
        logic div_done;
    } t_sts;

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] v);
        if (v > $signed({1'b0, S48_MAX})) return S48_MAX;
        if (v < $signed({1'b1, S48_MIN})) return S48_MIN;
        return v[SUM_W-1:0];
    endfunction

endpackage

### rtl/sbpa_div.sv
module sbpa_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [sbpa_pkg::SUM_W-1:0] i_num,
    input  logic [sbpa_pkg::HITS_W-1:0]     i_den,
    output logic                            o_done,
    output logic signed [sbpa_pkg::SUM_W-1:0] o_quo
);
    import sbpa_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_q, n_q;
    logic [HITS_W:0]   r_rem, n_rem;
    logic [HITS_W-1:0] r_den;
    logic              r_neg, r_busy, r_zero;
    logic [CNT_W-1:0]  r_cnt;
    logic [HITS_W:0]   w_trial;
    logic [HITS_W+1:0] w_sub;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_trial = {r_rem[HITS_W-1:0], r_q[SUM_W-1]};
        w_sub   = {1'b0, w_trial} - {2'b00, r_den};
        n_q     = {r_q[SUM_W-2:0], ~w_sub[HITS_W+1]};
        n_rem   = w_sub[HITS_W+1] ? w_trial : w_sub[HITS_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
                r_q    <= i_num[SUM_W-1] ? SUM_W'(-i_num) : i_num;
                r_neg  <= i_num[SUM_W-1];
                r_rem  <= '0;
                r_den  <= i_den;
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_zero ? '0 : (r_neg ? -$signed(r_q) : $signed(r_q));

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("divide done not a pulse");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divide restarted while busy");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("divide done while busy");

endmodule

### rtl/sbpa_datapath.sv
module sbpa_datapath #(
    parameter int MAX_SLICES = sbpa_pkg::MAX_SLICES_D,
    parameter int MAX_ATOMS  = sbpa_pkg::MAX_ATOMS_D,
    parameter int FRAC_BITS  = sbpa_pkg::FRAC_BITS_D
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sbpa_pkg::t_in_word      i_in,
    input  sbpa_pkg::t_cmd          i_cmd,
    input  logic [$clog2(MAX_SLICES+1)-1:0] i_slice,
    input  logic                    i_mode,
    input  logic signed [31:0]      i_z_low,
    input  logic signed [31:0]      i_z_high,
    input  logic [31:0]             i_inv,
    input  logic [30:0]             i_box_y,
    input  logic [$clog2(MAX_SLICES+1)-1:0] i_nused,
    output sbpa_pkg::t_sts          o_sts,
    output sbpa_pkg::t_out_word     o_out
);
    import sbpa_pkg::*;

    localparam int SI_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int AI_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

    t_in_word  r_in;
    logic      r_first;
    logic [31:0] r_frame;
    t_out_word r_out;

    // position memory, no reset
    logic signed [SUM_W-1:0] r_prev_mem [MAX_ATOMS];
    logic signed [SUM_W-1:0] r_prev;

    // slice memories with valid bits
    logic signed [SUM_W-1:0]  r_sum_mem  [MAX_SLICES];
    logic [HITS_W-1:0]        r_hits_mem [MAX_SLICES];
    logic [MAX_SLICES-1:0]    r_sval;
    logic signed [SUM_W-1:0]  r_sum_rd;
    logic [HITS_W-1:0]        r_hits_rd;
    logic                     r_sval_rd;

    logic signed [SUM_W-1:0]  r_unwr;
    logic [63:0]              r_prod;
    logic                     r_inrange, r_idx_ok;
    logic [SI_W-1:0]          r_k;

    logic signed [SUM_W-1:0]  w_unwr;
    logic signed [32:0]       w_diff;
    logic [SI_W-1:0]          w_k, w_addr;
    logic [31:0]              w_kraw;
    logic signed [SUM_W-1:0]  w_val, w_sum_old, w_sum_new;
    logic [HITS_W-1:0]        w_hits_old;
    logic                     w_idx_ok_in;
    logic                     w_div_done;
    logic signed [SUM_W-1:0]  w_quo;

    assign w_idx_ok_in = ({1'b0, i_in.atom_index} < 17'(MAX_ATOMS)) || (MAX_ATOMS >= 65536);
    assign w_unwr = SUM_W'(i_in.pos_y) + SUM_W'(i_in.image_y) * $signed({17'b0, i_box_y});
    assign w_diff = 33'(i_in.pos_z) - 33'(i_z_low);

    // capture word, products and previous position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in      <= i_in;
            r_unwr    <= w_unwr;
            r_prod    <= {32'b0, w_diff[31:0]} * {32'b0, i_inv};
            r_inrange <= (i_in.pos_z >= i_z_low) && (i_in.pos_z <= i_z_high);
            r_idx_ok  <= w_idx_ok_in;
            r_prev    <= r_prev_mem[AI_W'(i_in.atom_index)];
        end
    end

    // slice select with clamp
    always_comb begin
        w_kraw = 32'(r_prod >> (2 * FRAC_BITS));
        if (w_kraw >= 32'(i_nused)) w_k = SI_W'(i_nused - 1'b1);
        else                        w_k = SI_W'(w_kraw);
        w_addr = i_cmd.mul ? w_k : SI_W'(i_slice);
    end

    // slice read, registered
    always_ff @(posedge i_clk) begin
        r_sum_rd  <= r_sum_mem[w_addr];
        r_hits_rd <= r_hits_mem[w_addr];
        r_sval_rd <= r_sval[w_addr];
        if (i_cmd.mul) r_k <= w_k;
    end

    always_comb begin
        w_sum_old  = r_sval_rd ? r_sum_rd : '0;
        w_hits_old = r_sval_rd ? r_hits_rd : '0;
        if (i_mode && !r_first) begin
            w_val = sat48({r_unwr[SUM_W-1], r_unwr} -
                          {(r_idx_ok ? r_prev[SUM_W-1] : 1'b0), (r_idx_ok ? r_prev : '0)});
        end else begin
            w_val = SUM_W'(r_in.vel_y);
        end
        w_sum_new = sat48({w_sum_old[SUM_W-1], w_sum_old} + {w_val[SUM_W-1], w_val});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            if (r_idx_ok) r_prev_mem[AI_W'(r_in.atom_index)] <= r_unwr;
            if (r_inrange && w_hits_old != HITS_MAX) begin
                r_sum_mem[r_k]  <= w_sum_new;
                r_hits_mem[r_k] <= w_hits_old + 1'b1;
            end
        end
    end

    // valid bits, first-frame flag and frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sval  <= '0;
            r_first <= 1'b1;
            r_frame <= '0;
        end else begin
            if (i_cmd.upd && r_inrange && w_hits_old != HITS_MAX) r_sval[r_k] <= 1'b1;
            if (i_cmd.clr) r_sval[SI_W'(i_slice)] <= 1'b0;
            if (i_cmd.first_clr) r_first <= 1'b0;
            if (i_cmd.upd && r_in.frame_end) r_frame <= r_frame + 1'b1;
        end
    end

    // held result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_out.frame_number  <= r_frame;
            r_out.slice_index   <= 6'(i_slice);
            r_out.slice_average <= w_quo;
            r_out.last_slice    <= (i_slice == i_nused - 1'b1);
        end
    end

    sbpa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_sum_old),
        .i_den  (w_hits_old),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    assign o_out           = r_out;
    assign o_sts.frame_end = r_in.frame_end;
    assign o_sts.div_done  = w_div_done;

    a_upd_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |-> $past(i_cmd.mul)) else $error("update without slice read");
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr && i_cmd.upd)) else $error("clear during update");
    a_first_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.first_clr |=> !r_first) else $error("first frame not left");

endmodule

### rtl/sbpa_ctrl.sv
module sbpa_ctrl #(
    parameter int MAX_SLICES = sbpa_pkg::MAX_SLICES_D
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  sbpa_pkg::t_sts          i_sts,
    input  logic [$clog2(MAX_SLICES+1)-1:0] i_nused,
    output sbpa_pkg::t_cmd          o_cmd,
    output logic [$clog2(MAX_SLICES+1)-1:0] o_slice
);
    import sbpa_pkg::*;

    localparam int SL_W = $clog2(MAX_SLICES+1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [SL_W-1:0] r_slice, n_slice;
    logic            w_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;
    assign o_slice    = r_slice;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_slice = r_slice;
        unique case (r_state)
            S_IDLE: if (w_fire) begin
                o_cmd.load = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_slice   = '0;
                n_state   = i_sts.frame_end ? S_RD : S_IDLE;
            end
            S_RD: n_state = S_DST;
            S_DST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: if (i_sts.div_done) begin
                o_cmd.cap = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: if (i_out_ready) begin
                o_cmd.clr = 1'b1;
                if (r_slice == i_nused - 1'b1) begin
                    o_cmd.first_clr = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_slice = r_slice + 1'b1;
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, slice counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slice     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slice <= n_slice;
            if (o_cmd.cap) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OUT) else $error("result outside report");
    a_slice_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_slice < i_nused) else $error("slice beyond range");
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("accept during report");

endmodule

### rtl/slice_binned_profile_average_core.sv
// An ordinary word passes through capture, slice read and update.
// A frame_end word then reports each slice in use in turn: slice read,
// divide start, the bit-serial divide and its done, and the result being
// taken; the one shared divider serves every slice.
// A new word is taken only when idle, after the last word and its report.
// Reset: synchronous active low; clears control, configuration, first-frame flag, frame count and slice valid bits.
module slice_binned_profile_average_core #(
    parameter int MAX_SLICES = sbpa_pkg::MAX_SLICES_D,
    parameter int MAX_ATOMS  = sbpa_pkg::MAX_ATOMS_D,
    parameter int FRAC_BITS  = sbpa_pkg::FRAC_BITS_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sbpa_pkg::t_in_word          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sbpa_pkg::t_out_word         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [sbpa_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [sbpa_pkg::CFG_W-1:0]  i_cfg_data
);
    import sbpa_pkg::*;

    localparam int SL_W = $clog2(MAX_SLICES+1);

    logic               r_mode;
    logic signed [31:0] r_z_low, r_z_high;
    logic [6:0]         r_count;
    logic [31:0]        r_inv;
    logic [30:0]        r_box_y;
    logic [SL_W-1:0]    w_nused, w_slice;
    t_cmd               w_cmd;
    t_sts               w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_z_low  <= '0;
            r_z_high <= '0;
            r_count  <= 7'd1;
            r_inv    <= 32'd65536;
            r_box_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode   <= i_cfg_data[0];
                REG_ZLOW:  r_z_low  <= i_cfg_data;
                REG_ZHIGH: r_z_high <= i_cfg_data;
                REG_COUNT: r_count  <= i_cfg_data[6:0];
                REG_INV:   r_inv    <= i_cfg_data;
                REG_BOXY:  r_box_y  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // slices in use, clamped
    always_comb begin
        if (r_count == '0)                  w_nused = SL_W'(1);
        else if (32'(r_count) > MAX_SLICES) w_nused = SL_W'(MAX_SLICES);
        else                                w_nused = SL_W'(r_count);
    end

    sbpa_ctrl #(.MAX_SLICES(MAX_SLICES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .i_nused    (w_nused),
        .o_cmd      (w_cmd),
        .o_slice    (w_slice)
    );

    sbpa_datapath #(
        .MAX_SLICES(MAX_SLICES),
        .MAX_ATOMS (MAX_ATOMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (w_cmd),
        .i_slice (w_slice),
        .i_mode  (r_mode),
        .i_z_low (r_z_low),
        .i_z_high(r_z_high),
        .i_inv   (r_inv),
        .i_box_y (r_box_y),
        .i_nused (w_nused),
        .o_sts   (w_sts),
        .o_out   (o_out_data)
    );

endmodule
